/* rtl/lpsw_pkg.sv */
`default_nettype none

package lpsw_pkg;

  // Default geometry of the shadow store
  localparam int BYTE_COLUMNS_DEF = 16;
  localparam int PIXEL_ROWS_DEF   = 64;

  localparam int BYTE_W = 8;

  // Request codes
  typedef enum logic [1:0] {
    FUNC_SET    = 2'd0,
    FUNC_CLR    = 2'd1,
    FUNC_CURSOR = 2'd2
  } func_e;

  // Controller command bases
  localparam logic [7:0] CMD_COL_MASK = 8'h0F;
  localparam logic [7:0] CMD_ROW_LO   = 8'h20;
  localparam logic [7:0] CMD_ROW_HI   = 8'h30;
  localparam logic [7:0] PIX_MSB      = 8'h80;

  // Upper nibble of each command byte, for checking
  localparam logic [3:0] NIB_COL    = 4'h0;
  localparam logic [3:0] NIB_ROW_LO = 4'h2;
  localparam logic [3:0] NIB_ROW_HI = 4'h3;

endpackage

`default_nettype wire

/* rtl/lcd_pixel_shadow_command_writer.sv */
// Flow: a pixel request passes the store read state ST_READ, then shows its
//   four bytes on the result channel, one per cycle when not stalled.
// Requests: a cursor request shows its three command bytes; a rejected one is
//   dropped. One request is in flight at a time: the input stalls until idle.
// Reset: asynchronous, active low. Afterwards a clearing pass zeroes all
//   BYTE_COLUMNS*PIXEL_ROWS entries (1024 by default), with the input stalled.
`default_nettype none

module lcd_pixel_shadow_command_writer #(
  parameter int BYTE_COLUMNS = lpsw_pkg::BYTE_COLUMNS_DEF,
  parameter int PIXEL_ROWS   = lpsw_pkg::PIXEL_ROWS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // request channel
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] func_i,
  input  wire logic [7:0] x_i,
  input  wire logic [7:0] y_i,
  // controller byte channel
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      byte_out_o,
  output logic            is_command_o,
  output logic            last_o
);

  localparam int DEPTH = BYTE_COLUMNS * PIXEL_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } state_e;

  state_e          state_q;
  logic [AW-1:0]   clr_q;
  logic [1:0]      idx_q;
  logic            pixel_q;   // run carries a data byte
  logic            set_q;
  logic [7:0]      mask_q;
  logic [3:0]      col_q;
  logic [6:0]      row_q;
  logic [7:0]      data_q;
  logic [AW-1:0]   addr_q;

  // Request decode
  logic            in_xfer;
  logic            pix_req;
  logic            cur_req;
  logic [4:0]      pix_col;
  logic [AW-1:0]   pix_addr;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign pix_col  = x_i[7:3];
  assign pix_addr = AW'(y_i[6:0]) * AW'(BYTE_COLUMNS) + AW'(pix_col);

  assign pix_req = ((func_i == lpsw_pkg::FUNC_SET) || (func_i == lpsw_pkg::FUNC_CLR))
                && ({1'b0, x_i} < 9'(BYTE_COLUMNS * 8))
                && ({1'b0, y_i} < 9'(PIXEL_ROWS));
  assign cur_req = (func_i == lpsw_pkg::FUNC_CURSOR)
                && ({1'b0, x_i} < 9'(BYTE_COLUMNS))
                && ({1'b0, y_i} < 9'(PIXEL_ROWS));

  // Shadow store port: clear sweep, read at accept, write back in ST_READ
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;
  logic [7:0]    upd_byte;

  assign upd_byte = set_q ? (ram_rdata | mask_q) : (ram_rdata & ~mask_q);

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = pix_addr;
    ram_wdata = upd_byte;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
      end
      ST_READ: begin
        ram_we   = 1'b1;
        ram_addr = addr_q;
      end
      ST_IDLE, ST_EMIT: begin
        ram_we = 1'b0;
      end
      default: ram_we = 1'b0;
    endcase
  end

  lpsw_ram #(
    .WIDTH (lpsw_pkg::BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Output byte selection from the run registers
  logic out_xfer;
  logic run_end;

  assign out_valid_o = (state_q == ST_EMIT);
  assign out_xfer    = out_valid_o && !out_stall_i;
  assign run_end     = pixel_q ? (idx_q == 2'd3) : (idx_q == 2'd2);
  assign last_o      = run_end;

  always_comb begin
    byte_out_o   = lpsw_pkg::CMD_COL_MASK & {4'h0, col_q};
    is_command_o = 1'b1;
    unique case (idx_q)
      2'd0: byte_out_o = lpsw_pkg::CMD_COL_MASK & {4'h0, col_q};
      2'd1: byte_out_o = lpsw_pkg::CMD_ROW_LO | {4'h0, row_q[3:0]};
      2'd2: byte_out_o = lpsw_pkg::CMD_ROW_HI | {5'h0, row_q[6:4]};
      2'd3: begin
        byte_out_o   = data_q;
        is_command_o = 1'b0;
      end
      default: byte_out_o = data_q;
    endcase
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      idx_q   <= '0;
      pixel_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_CLEAR: begin
          if (clr_q == AW'(DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end
          clr_q <= clr_q + 1'b1;
        end
        ST_IDLE: begin
          idx_q <= '0;
          if (in_xfer && pix_req) begin
            pixel_q <= 1'b1;
            state_q <= ST_READ;
          end else if (in_xfer && cur_req) begin
            pixel_q <= 1'b0;
            state_q <= ST_EMIT;
          end
        end
        ST_READ: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_xfer) begin
            if (run_end) begin
              state_q <= ST_IDLE;
            end
            idx_q <= idx_q + 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Request payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      set_q  <= (func_i == lpsw_pkg::FUNC_SET);
      mask_q <= lpsw_pkg::PIX_MSB >> x_i[2:0];
      col_q  <= pix_req ? pix_col[3:0] : x_i[3:0];
      row_q  <= y_i[6:0];
      addr_q <= pix_addr;
    end
    if (state_q == ST_READ) begin
      data_q <= upd_byte;
    end
  end

endmodule

`default_nettype wire

/* rtl/lpsw_ram.sv */
`default_nettype none

module lpsw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

/* rtl/lpsw_checker.sv */
`default_nettype none

module lpsw_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic [1:0] func_i,
  input wire logic [7:0] x_i,
  input wire logic [7:0] y_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] byte_out_o,
  input wire logic       is_command_o,
  input wire logic       last_o
);

  // One request at a time: no new request while bytes are pending
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("request accepted while a run is pending");

  // A data byte always closes its run
  a_data_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !is_command_o) |-> last_o)
    else $error("data byte not marked last");

  // A command byte that ends a run is the row high command
  a_cmd_last_row_hi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_command_o && last_o) |->
      (byte_out_o[7:4] == lpsw_pkg::NIB_ROW_HI))
    else $error("cursor run ends on wrong command");

  // A run starts with the column command
  a_run_start_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |->
      (is_command_o && (byte_out_o[7:4] == lpsw_pkg::NIB_COL)))
    else $error("run does not start with column command");

  // Stalled byte holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(byte_out_o) && $stable(last_o)))
    else $error("stalled byte changed");

endmodule

bind lcd_pixel_shadow_command_writer lpsw_checker u_lpsw_checker (.*);

`default_nettype wire
